FILE: rtl/sctab_pkg.sv
// Shared types and constants for the sorted case table.
package sctab_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int CNT_W       = 7;
    localparam int KEY_W       = 16;
    localparam int LABEL_W     = 16;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_DUMP   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_FULL  = 3'd2,
        ST_ENTRY = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [LABEL_W-1:0]      label;
    } pair_t;

    // ins: every cell at or right of the slot takes its new content
    // rot: the whole table moves one place toward cell 0 (dump)
    typedef struct packed {
        logic ins;
        logic rot;
    } cell_ctrl_t;

endpackage

FILE: rtl/sctab_if.sv
// Handshake channel interfaces for requests and responses.
interface sctab_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic signed [15:0] case_value;
    logic [15:0] case_label;

    modport source (output valid, output opcode, output case_value, output case_label,
                    input ready);
    modport sink   (input valid, input opcode, input case_value, input case_label,
                    output ready);
endinterface

interface sctab_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic signed [15:0] entry_value;
    logic [15:0] entry_label;
    logic [6:0]  entry_count;
    logic        last;

    modport source (output valid, output status, output entry_value, output entry_label,
                    output entry_count, output last, input ready);
    modport sink   (input valid, input status, input entry_value, input entry_label,
                    input entry_count, input last, output ready);
endinterface

FILE: rtl/sctab_cell.sv
// One table slot: holds a pair, compares it with the new key, shifts with its neighbors.
module sctab_cell (
    input  logic                   clk,
    input  sctab_pkg::cell_ctrl_t  ctrl,
    input  logic                   occupied,
    input  logic                   wrap,
    input  logic                   left_shift,
    input  sctab_pkg::pair_t       new_pair,
    input  sctab_pkg::pair_t       left_pair,
    input  sctab_pkg::pair_t       right_pair,
    input  sctab_pkg::pair_t       head_pair,
    output sctab_pkg::pair_t       pair,
    output logic                   shift,
    output logic                   match
);

    sctab_pkg::pair_t pair_reg;
    sctab_pkg::pair_t pair_next;

    // an empty slot counts as larger than any key
    assign shift = !occupied || (pair_reg.key > new_pair.key);
    assign match = occupied && (pair_reg.key == new_pair.key);
    assign pair  = pair_reg;

    always_comb
    begin
        pair_next = pair_reg;
        if (ctrl.ins && shift)
        begin
            pair_next = left_shift ? left_pair : new_pair;
        end
        else if (ctrl.rot)
        begin
            // last occupied slot refills from the head so the table comes back whole
            pair_next = wrap ? head_pair : right_pair;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
    end

endmodule

FILE: rtl/sorted_case_table_insert.sv
// Top level: sorted (key, label) table built as a row of shifting cells.
//
// Requests arrive on req (opcode, case_value, case_label); results leave on rsp
// (status, entry_value, entry_label, entry_count, last), both valid/ready.
// Clear and insert give one result with last set. An insert
// is compared against all cells at once; the cells at and beyond the sorted
// slot shift one place right in the same cycle, so no table walk is needed.
// A refused insert (duplicate or full) leaves the table untouched.
// Dump of n entries gives n results, one per cycle unless rsp stalls, entry order by key; the
// cell row rotates one place per result and is back in order after the last.
// Dump of an empty table gives a single empty-table result.
// Opcode 3 is taken and dropped with no result.
// Results sit in one output register. The next request is taken in a cycle
// where that register is empty or being read, so clear and insert run one per
// cycle while rsp does not stall, and a dump holds req off until its last
// result is registered. A stall on rsp holds the register, blocks req and
// pauses the dump.
// Reset empties the table (fill count zero); stored pairs are not cleared.
module sorted_case_table_insert (
    input  logic        clk,
    input  logic        rst_n,
    sctab_req_if.sink   req,
    sctab_rsp_if.source rsp
);

    localparam int DEPTH = sctab_pkg::TABLE_DEPTH;
    localparam int CNT_W = sctab_pkg::CNT_W;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic                      out_valid_reg, out_valid_next;
    sctab_pkg::status_t        status_reg, status_next;
    sctab_pkg::pair_t          out_pair_reg, out_pair_next;
    logic [CNT_W-1:0]          out_count_reg, out_count_next;
    logic                      out_last_reg, out_last_next;

    sctab_pkg::cell_ctrl_t     ctrl;
    sctab_pkg::pair_t          new_pair;
    sctab_pkg::pair_t          cell_pair [DEPTH];
    logic [DEPTH-1:0]          cell_shift;
    logic [DEPTH-1:0]          cell_match;

    logic                      slot_free;
    logic                      req_fire;
    logic                      is_full;
    logic                      is_dup;

    assign new_pair.key   = req.case_value;
    assign new_pair.label = req.case_label;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            sctab_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (CNT_W'(i) < count_reg),
                .wrap       (CNT_W'(i + 1) == count_reg),
                .left_shift (i == 0 ? 1'b0 : cell_shift[(i == 0) ? 0 : i - 1]),
                .new_pair   (new_pair),
                .left_pair  (cell_pair[(i == 0) ? 0 : i - 1]),
                .right_pair (cell_pair[(i == DEPTH - 1) ? 0 : i + 1]),
                .head_pair  (cell_pair[0]),
                .pair       (cell_pair[i]),
                .shift      (cell_shift[i]),
                .match      (cell_match[i])
            );
        end
    endgenerate

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && slot_free;
    assign req_fire  = req.valid && req.ready;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_dup    = |cell_match;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        out_pair_next  = out_pair_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        ctrl           = '0;

        if (req_fire)
        begin
            out_pair_next  = '0;
            out_last_next  = 1'b1;
            out_count_next = count_reg;
            case (sctab_pkg::opcode_t'(req.opcode))
                sctab_pkg::OP_CLEAR:
                begin
                    count_next     = '0;
                    out_count_next = '0;
                    status_next    = sctab_pkg::ST_OK;
                    out_valid_next = 1'b1;
                end
                sctab_pkg::OP_INSERT:
                begin
                    out_valid_next = 1'b1;
                    if (is_full)
                    begin
                        status_next = sctab_pkg::ST_FULL;
                    end
                    else if (is_dup)
                    begin
                        status_next = sctab_pkg::ST_DUP;
                    end
                    else
                    begin
                        ctrl.ins       = 1'b1;
                        count_next     = count_reg + 1'b1;
                        out_count_next = count_reg + 1'b1;
                        status_next    = sctab_pkg::ST_OK;
                    end
                end
                sctab_pkg::OP_DUMP:
                begin
                    out_valid_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        status_next = sctab_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        // first entry goes out now, the rest from the dump state
                        ctrl.rot      = 1'b1;
                        status_next   = sctab_pkg::ST_ENTRY;
                        out_pair_next = cell_pair[0];
                        out_last_next = (count_reg == CNT_W'(1));
                        idx_next      = CNT_W'(1);
                        if (count_reg != CNT_W'(1))
                        begin
                            state_next = S_DUMP;
                        end
                    end
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !rsp.ready;
                end
            endcase
        end
        else if (state_reg == S_DUMP && slot_free)
        begin
            ctrl.rot       = 1'b1;
            out_valid_next = 1'b1;
            status_next    = sctab_pkg::ST_ENTRY;
            out_pair_next  = cell_pair[0];
            out_count_next = count_reg;
            out_last_next  = (idx_reg + 1'b1 == count_reg);
            idx_next       = idx_reg + 1'b1;
            if (idx_reg + 1'b1 == count_reg)
            begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= sctab_pkg::ST_OK;
            out_pair_reg  <= '0;
            out_count_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            out_pair_reg  <= out_pair_next;
            out_count_reg <= out_count_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_value = out_pair_reg.key;
    assign rsp.entry_label = out_pair_reg.label;
    assign rsp.entry_count = out_count_reg;
    assign rsp.last        = out_last_reg;

endmodule
